>>> src/marker_length_packet_deframer_assert.svh
// Assertion macros shared by the deframer modules.
`ifndef MARKER_LENGTH_PACKET_DEFRAMER_ASSERT_SVH
`define MARKER_LENGTH_PACKET_DEFRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property at every clock edge outside reset.
`define MLPD_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a trigger is followed by a property on the next edge.
`define MLPD_ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) else $error(msg);
`else
`define MLPD_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define MLPD_ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg)
`endif
`endif

>>> src/mlpd_pkg.sv
// Package: types, constants and register codes of the packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package mlpd_pkg;

  // Register defaults
  localparam logic [7:0]  BINARY_MARKER_RST   = 8'd36;
  localparam logic [31:0] TEXT_MARKER_RST     = 32'd218762506;
  localparam logic [2:0]  TEXT_MARKER_LEN_RST = 3'd4;

  // Design defaults
  localparam int MAX_MARKER_LEN_DEF = 4;
  localparam int LEN_BYTES_DEF      = 4;

  // Marker register holds four bytes, so at most three are held back
  localparam int HOLD_DEPTH = 3;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_BINARY_MARKER   = 2'd0;
  localparam logic [1:0] REG_TEXT_MARKER     = 2'd1;
  localparam logic [1:0] REG_TEXT_MARKER_LEN = 2'd2;

  // Packet kinds
  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_BINARY = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TEXT,
    PH_LEN,
    PH_PAYLOAD
  } mlpd_phase_t;

  typedef struct packed {
    logic [7:0]  binary_marker;
    logic [31:0] text_marker;
    logic [2:0]  text_marker_len;
  } mlpd_cfg_t;

  typedef struct packed {
    logic       pkt_kind;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
  } mlpd_item_t;

endpackage
`default_nettype wire

>>> src/marker_length_packet_deframer.sv
// Top level: marker and length prefixed packet deframer with register port.
// Usage:
//   in_*   : one raw stream byte per request on in_tdata[7:0].
//   out_*  : one result per request; out_tdata[7:0] is the payload byte,
//            out_tuser[0] the packet kind (0 text, 1 binary), out_tuser[1]
//            set when the byte is payload (clear for a bare end item), and
//            out_tlast marks the end of a packet.
//   cfg_*  : register port; 0x0 binary marker, 0x4 text end marker,
//            0x8 text marker length. Write only while the stream is idle.
// The parser handles each accepted input byte and writes any result into the
// four-entry result queue, from which it is loaded into the output register
// that drives out_*. Sustained rate is one byte per cycle while the queue
// has room.
// Text bytes are held back by up to three bytes so the end marker is cut.
// Reset (synchronous, rst_n low) returns the parser to idle, empties the
// queue and restores register defaults. When the receiver stalls, results
// pile up in the queue and in_tready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none
module marker_length_packet_deframer #(
  parameter int MAX_MARKER_LEN = mlpd_pkg::MAX_MARKER_LEN_DEF,
  parameter int LEN_BYTES      = mlpd_pkg::LEN_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,     // [7:0] in_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,    // [7:0] out_byte
  output logic [1:0]  out_tuser,    // [0] pkt_kind, [1] byte_valid
  output logic        out_tlast,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mlpd_pkg::mlpd_cfg_t  cfg_r;
  mlpd_pkg::mlpd_item_t push_item, q_item, out_item;
  logic                 push, pop, q_full, q_empty, in_accept, wr_en;

  // Register port
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.binary_marker   <= mlpd_pkg::BINARY_MARKER_RST;
      cfg_r.text_marker     <= mlpd_pkg::TEXT_MARKER_RST;
      cfg_r.text_marker_len <= mlpd_pkg::TEXT_MARKER_LEN_RST;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        mlpd_pkg::REG_BINARY_MARKER:   cfg_r.binary_marker   <= cfg_pwdata[7:0];
        mlpd_pkg::REG_TEXT_MARKER:     cfg_r.text_marker     <= cfg_pwdata;
        mlpd_pkg::REG_TEXT_MARKER_LEN: cfg_r.text_marker_len <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_paddr[3:2])
      mlpd_pkg::REG_BINARY_MARKER:   cfg_prdata = {24'd0, cfg_r.binary_marker};
      mlpd_pkg::REG_TEXT_MARKER:     cfg_prdata = cfg_r.text_marker;
      mlpd_pkg::REG_TEXT_MARKER_LEN: cfg_prdata = {29'd0, cfg_r.text_marker_len};
      default:                       cfg_prdata = 32'd0;
    endcase
  end

  // Take a byte whenever the queue has room
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  mlpd_front #(
    .MAX_MARKER_LEN (MAX_MARKER_LEN),
    .LEN_BYTES      (LEN_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .push      (push),
    .push_item (push_item)
  );

  mlpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  mlpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .pop        (pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_item   (out_item)
  );

  assign out_tdata = out_item.out_byte;
  assign out_tuser = {out_item.byte_valid, out_item.pkt_kind};
  assign out_tlast = out_item.last;

endmodule
`default_nettype wire

>>> src/mlpd_front.sv
// Front end: frame parser that classifies each byte and produces result requests.
`timescale 1ns / 1ps
`default_nettype none
`include "marker_length_packet_deframer_assert.svh"
module mlpd_front #(
  parameter int MAX_MARKER_LEN = mlpd_pkg::MAX_MARKER_LEN_DEF,
  parameter int LEN_BYTES      = mlpd_pkg::LEN_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mlpd_pkg::mlpd_cfg_t cfg,
  input  wire                 in_accept,
  input  wire [7:0]           in_byte,
  output logic                push,
  output mlpd_pkg::mlpd_item_t push_item
);

  localparam int CAP    = (MAX_MARKER_LEN < 4) ? MAX_MARKER_LEN : 4;
  localparam int LIDX_W = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;

  mlpd_pkg::mlpd_phase_t phase_r, phase_nxt;
  logic [7:0]            held_r   [mlpd_pkg::HOLD_DEPTH];
  logic [7:0]            held_nxt [mlpd_pkg::HOLD_DEPTH];
  logic [1:0]            held_count_r, held_count_nxt;
  logic [31:0]           length_r, length_nxt;
  logic [LIDX_W-1:0]     lidx_r, lidx_nxt;

  logic [2:0]  mlen;
  logic [1:0]  need;
  logic [1:0]  hc;
  logic [1:0]  idx;
  logic        fill;
  logic        match;
  logic [31:0] len_acc;
  logic        len_done;
  logic        is_marker;

  // Decode marker window, match and length accumulation
  always_comb begin
    mlen = cfg.text_marker_len;
    if (mlen == 3'd0) mlen = 3'd1;
    if (32'(mlen) > CAP) mlen = 3'(CAP);
    need = 2'(mlen - 3'd1);
    hc   = (phase_r == mlpd_pkg::PH_IDLE) ? 2'd0 : held_count_r;
    fill = (hc < need);
    idx  = 2'd0;
    match = (cfg.text_marker[{need, 3'b000} +: 8] == in_byte);
    for (int i = 0; i < mlpd_pkg::HOLD_DEPTH; i++) begin
      if (i < 32'(need)) begin
        idx = 2'(hc - need + 2'(i));
        if (held_r[idx] != cfg.text_marker[8*i +: 8]) match = 1'b0;
      end
    end
    len_acc = length_r;
    for (int k = 0; k < 4; k++) begin
      if (32'(lidx_r) == k) len_acc[8*k +: 8] = length_r[8*k +: 8] | in_byte;
    end
    len_done  = (32'(lidx_r) == LEN_BYTES - 1);
    is_marker = (in_byte == cfg.binary_marker);
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_accept) begin
      case (phase_r)
        mlpd_pkg::PH_IDLE: begin
          if (is_marker) phase_nxt = mlpd_pkg::PH_LEN;
          else if (!fill && match) phase_nxt = mlpd_pkg::PH_IDLE;
          else phase_nxt = mlpd_pkg::PH_TEXT;
        end
        mlpd_pkg::PH_TEXT: begin
          if (!fill && match) phase_nxt = mlpd_pkg::PH_IDLE;
        end
        mlpd_pkg::PH_LEN: begin
          if (len_done) begin
            phase_nxt = (len_acc == 32'd0) ? mlpd_pkg::PH_IDLE : mlpd_pkg::PH_PAYLOAD;
          end
        end
        mlpd_pkg::PH_PAYLOAD: begin
          if (length_r == 32'd1) phase_nxt = mlpd_pkg::PH_IDLE;
        end
        default: phase_nxt = mlpd_pkg::PH_IDLE;
      endcase
    end
  end

  // Results and datapath updates
  always_comb begin
    push           = 1'b0;
    push_item      = '0;
    held_nxt       = held_r;
    held_count_nxt = held_count_r;
    length_nxt     = length_r;
    lidx_nxt       = lidx_r;
    if (in_accept) begin
      case (phase_r)
        mlpd_pkg::PH_IDLE, mlpd_pkg::PH_TEXT: begin
          if ((phase_r == mlpd_pkg::PH_IDLE) && is_marker) begin
            length_nxt = 32'd0;
            lidx_nxt   = '0;
          end else if (fill) begin
            // Hold the byte until the window is full
            held_nxt[hc]   = in_byte;
            held_count_nxt = hc + 2'd1;
          end else if (match) begin
            // Drop the marker and close the packet
            push           = 1'b1;
            push_item      = '{mlpd_pkg::KIND_TEXT, 8'd0, 1'b0, 1'b1};
            held_count_nxt = 2'd0;
          end else if (hc == 2'd0) begin
            push           = 1'b1;
            push_item      = '{mlpd_pkg::KIND_TEXT, in_byte, 1'b1, 1'b0};
            held_count_nxt = 2'd0;
          end else begin
            // Emit the oldest held byte and advance the window
            push      = 1'b1;
            push_item = '{mlpd_pkg::KIND_TEXT, held_r[0], 1'b1, 1'b0};
            for (int i = 1; i < mlpd_pkg::HOLD_DEPTH; i++) begin
              if (i < 32'(hc)) held_nxt[i-1] = held_r[i];
            end
            held_nxt[hc - 2'd1] = in_byte;
            held_count_nxt      = hc;
          end
        end
        mlpd_pkg::PH_LEN: begin
          length_nxt = len_acc;
          lidx_nxt   = LIDX_W'(lidx_r + 1'b1);
          if (len_done) begin
            lidx_nxt = '0;
            if (len_acc == 32'd0) begin
              push      = 1'b1;
              push_item = '{mlpd_pkg::KIND_BINARY, 8'd0, 1'b0, 1'b1};
            end
          end
        end
        mlpd_pkg::PH_PAYLOAD: begin
          length_nxt = length_r - 32'd1;
          push       = 1'b1;
          push_item  = '{mlpd_pkg::KIND_BINARY, in_byte, 1'b1, (length_r == 32'd1)};
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mlpd_pkg::PH_IDLE;
      held_count_r <= 2'd0;
      length_r     <= 32'd0;
      lidx_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      held_count_r <= held_count_nxt;
      length_r     <= length_nxt;
      lidx_r       <= lidx_nxt;
    end
  end

  // Held text bytes
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  `MLPD_ASSERT_ALWAYS(a_payload_len_nonzero, clk, rst_n,
    (phase_r != mlpd_pkg::PH_PAYLOAD) || (length_r != 32'd0), "payload phase with zero length")
  `MLPD_ASSERT_NEXT(a_end_returns_idle, clk, rst_n, push && push_item.last,
    phase_r == mlpd_pkg::PH_IDLE, "packet end did not return to idle")

endmodule
`default_nettype wire

>>> src/mlpd_fifo.sv
// Result queue between the frame parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none
`include "marker_length_packet_deframer_assert.svh"
module mlpd_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  mlpd_pkg::mlpd_item_t  push_item,
  input  wire                   pop,
  output mlpd_pkg::mlpd_item_t  pop_item,
  output logic                  full,
  output logic                  empty
);

  mlpd_pkg::mlpd_item_t              mem_r [mlpd_pkg::QDEPTH];
  logic [mlpd_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [mlpd_pkg::QCNT_W-1:0]       count_r, count_nxt;

  assign full     = (count_r == mlpd_pkg::QCNT_W'(mlpd_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  `MLPD_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full), "push into full queue")
  `MLPD_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && empty), "pop from empty queue")

endmodule
`default_nettype wire

>>> src/mlpd_back.sv
// Back end: output register that drains the result queue onto the stream.
`timescale 1ns / 1ps
`default_nettype none
`include "marker_length_packet_deframer_assert.svh"
module mlpd_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_empty,
  input  mlpd_pkg::mlpd_item_t  q_item,
  output logic                  pop,
  input  wire                   out_tready,
  output logic                  out_tvalid,
  output mlpd_pkg::mlpd_item_t  out_item
);

  logic                 valid_r;
  mlpd_pkg::mlpd_item_t item_r;

  // Load when the register is free or being taken
  assign pop        = !q_empty && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item_r <= q_item;
  end

  `MLPD_ASSERT_NEXT(a_load_shows, clk, rst_n, pop, valid_r, "loaded request not presented")

endmodule
`default_nettype wire
